// ----- hw/rtl/ecic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecic_pkg: shared types and constants of the external interrupt controller
// Holds the op and register codes, field widths and the per-line control
// bundle that travels from the decoder to the line lanes and the merge stage.
// ----------------------------------------------------------------------------
package ecic_pkg;

	// Field widths fixed by the bus and pin interface.
	localparam int LINES_MAX = 16;
	localparam int PORTS_MAX = 8;
	localparam int SEL_W     = 4;
	localparam int PIN_W     = 64;
	localparam int DATA_W    = 16;
	localparam int IRQ_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// Default configuration of the line and port counts.
	localparam int NUM_LINES_DEF = 16;
	localparam int NUM_PORTS_DEF = 8;

	// Item operation codes.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Bus register addresses.
	localparam logic ADDR_MASK = 1'b0;
	localparam logic ADDR_PEND = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_SEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_EN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_EN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

	// Decoded action of one accepted item.
	typedef struct packed {
		logic sample;
		logic mask_wr;
		logic pend_clr;
		logic rd_mask;
		logic rd_pend;
	} ecic_ctrl_t;

endpackage

// ----- hw/rtl/ecic_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecic_lane: one interrupt line
// Picks the line level from the selected port, detects edges against the
// stored level, and keeps the line's pending and mask bits.
// ----------------------------------------------------------------------------
module ecic_lane #(
	parameter int LINE      = 0,
	parameter int NUM_PORTS = ecic_pkg::NUM_PORTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ecic_pkg::ecic_ctrl_t         ctrl,
	input  logic [ecic_pkg::SEL_W-1:0]   sel,
	input  logic [ecic_pkg::PIN_W-1:0]   pins_low,
	input  logic [ecic_pkg::PIN_W-1:0]   pins_high,
	input  logic                         rise_en,
	input  logic                         fall_en,
	input  logic                         wr_bit,
	output logic                         pend_nx,
	output logic                         mask_nx
);

	logic       prev_q;
	logic       pend_q;
	logic       mask_q;
	logic       level;
	logic [5:0] bit_idx;
	logic [ecic_pkg::PIN_W-1:0] word;
	logic       edge_hit;

	// Level of the selected port; a selector without a port reads low.
	always_comb begin
		word    = sel[2] ? pins_high : pins_low;
		bit_idx = {sel[1:0], 4'(LINE)};
		level   = (sel < ecic_pkg::SEL_W'(NUM_PORTS)) ? word[bit_idx] : 1'b0;
	end

	// Edge detection and next pending and mask values.
	always_comb begin
		edge_hit = (level & ~prev_q & rise_en) | (~level & prev_q & fall_en);
		if (ctrl.sample) begin
			pend_nx = pend_q | edge_hit;
		end else if (ctrl.pend_clr) begin
			pend_nx = pend_q & ~wr_bit;
		end else begin
			pend_nx = pend_q;
		end
		mask_nx = ctrl.mask_wr ? wr_bit : mask_q;
	end

	// Line state; the stored level resets high as the pins are pulled up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			pend_q <= 1'b0;
			mask_q <= 1'b0;
		end else begin
			pend_q <= pend_nx;
			mask_q <= mask_nx;
			if (ctrl.sample) begin
				prev_q <= level;
			end
		end
	end

	// A pending bit is only set by a pin sample.
	a_pend_only_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.sample |=> !$rose(pend_q))
		else $error("pending bit set without a pin sample");

	// The mask only moves on a mask write.
	a_mask_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.mask_wr |=> $stable(mask_q))
		else $error("mask bit changed without a mask write");

	// The stored level only moves on a pin sample.
	a_level_only_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.sample |=> $stable(prev_q))
		else $error("stored level changed without a pin sample");

endmodule

// ----- hw/rtl/ecic_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecic_merge: result merge and output buffer
// Groups the masked pending bits of all lanes into interrupt requests,
// selects the read data, and holds results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module ecic_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ecic_pkg::ecic_ctrl_t               ctrl,
	input  logic [ecic_pkg::LINES_MAX-1:0]     pend_nx,
	input  logic [ecic_pkg::LINES_MAX-1:0]     mask_nx,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ecic_pkg::DATA_W-1:0]        read_data,
	output logic [ecic_pkg::IRQ_W-1:0]         irq_requests
);

	logic [ecic_pkg::LINES_MAX-1:0] active;
	logic [ecic_pkg::DATA_W-1:0]    rd_new;
	logic [ecic_pkg::IRQ_W-1:0]     irq_new;
	logic                           main_valid_q;
	logic                           skid_valid_q;
	logic [ecic_pkg::DATA_W-1:0]    main_rd_q;
	logic [ecic_pkg::IRQ_W-1:0]     main_irq_q;
	logic [ecic_pkg::DATA_W-1:0]    skid_rd_q;
	logic [ecic_pkg::IRQ_W-1:0]     skid_irq_q;
	logic                           push;
	logic                           pop;

	// Request grouping and read data selection from the updated state.
	always_comb begin
		active  = pend_nx & mask_nx;
		irq_new = {|active[15:10], |active[9:5], active[4:0]};
		rd_new  = '0;
		if (ctrl.rd_mask) begin
			rd_new = ecic_pkg::DATA_W'(mask_nx);
		end else if (ctrl.rd_pend) begin
			rd_new = ecic_pkg::DATA_W'(pend_nx);
		end
	end

	assign in_ready     = !skid_valid_q;
	assign push         = in_valid && in_ready;
	assign pop          = main_valid_q && out_ready;
	assign out_valid    = main_valid_q;
	assign read_data    = main_rd_q;
	assign irq_requests = main_irq_q;

	// Output buffer control: the skid entry catches a transfer while the
	// output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push && main_valid_q && !pop) begin
			skid_valid_q <= 1'b1;
		end else if (push) begin
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_rd_q  <= skid_rd_q;
				main_irq_q <= skid_irq_q;
			end
		end else if (push && main_valid_q && !pop) begin
			skid_rd_q  <= rd_new;
			skid_irq_q <= irq_new;
		end else if (push) begin
			main_rd_q  <= rd_new;
			main_irq_q <= irq_new;
		end
	end

	// The skid entry is never filled ahead of the output entry.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry holds a result while the output is empty");

	// Draining the skid entry keeps a result on the output.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q))
		else $error("skid entry lost while draining");

	// A transfer into a full output buffer cannot happen.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(main_valid_q && !pop && push) |=> skid_valid_q)
		else $error("result dropped on a stalled output");

endmodule

// ----- hw/rtl/external_interrupt_edge_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller: edge-triggered external interrupts
// Per-line port selection, edge detection into pending bits, a mask and
// pending register on the bus side, and grouped interrupt requests.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    op, reg_addr, write_data,
//                                              pins_low, pins_high
//   out      output     out_valid / out_ready  read_data, irq_requests
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock while in_ready is high: every line lane updates its state on
// the transfer, and the result is registered into the output entry, or into the
// skid entry of the two-entry buffer while the output stalls, so the input takes
// one more item after a stall; in_ready drops only when both entries are full.
// Reset clears pending and mask bits, sets the stored levels high and clears
// the configuration registers. cfg_ready is always high.
// ----------------------------------------------------------------------------
module external_interrupt_edge_controller #(
	parameter int NUM_LINES = ecic_pkg::NUM_LINES_DEF,
	parameter int NUM_PORTS = ecic_pkg::NUM_PORTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic                              reg_addr,
	input  logic [ecic_pkg::DATA_W-1:0]       write_data,
	input  logic [ecic_pkg::PIN_W-1:0]        pins_low,
	input  logic [ecic_pkg::PIN_W-1:0]        pins_high,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ecic_pkg::DATA_W-1:0]       read_data,
	output logic [ecic_pkg::IRQ_W-1:0]        irq_requests,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ecic_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecic_pkg::CFG_W-1:0]        cfg_data
);

	logic [ecic_pkg::CFG_W-1:0]     port_sel_q;
	logic [ecic_pkg::LINES_MAX-1:0] rise_en_q;
	logic [ecic_pkg::LINES_MAX-1:0] fall_en_q;
	logic [ecic_pkg::LINES_MAX-1:0] pend_nx;
	logic [ecic_pkg::LINES_MAX-1:0] mask_nx;
	logic                           accept;
	ecic_pkg::ecic_ctrl_t           ctrl;
	ecic_pkg::ecic_ctrl_t           lane_ctrl;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_sel_q <= '0;
			rise_en_q  <= '0;
			fall_en_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ecic_pkg::CFG_PORT_SEL: port_sel_q <= cfg_data;
				ecic_pkg::CFG_RISE_EN:  rise_en_q  <= cfg_data[ecic_pkg::LINES_MAX-1:0];
				ecic_pkg::CFG_FALL_EN:  fall_en_q  <= cfg_data[ecic_pkg::LINES_MAX-1:0];
				default: ;
			endcase
		end
	end

	// Op decode of the item on the input.
	always_comb begin
		ctrl = '0;
		unique case (op)
			ecic_pkg::OP_SAMPLE: ctrl.sample = 1'b1;
			ecic_pkg::OP_WRITE: begin
				ctrl.mask_wr  = (reg_addr == ecic_pkg::ADDR_MASK);
				ctrl.pend_clr = (reg_addr == ecic_pkg::ADDR_PEND);
			end
			ecic_pkg::OP_READ: begin
				ctrl.rd_mask = (reg_addr == ecic_pkg::ADDR_MASK);
				ctrl.rd_pend = (reg_addr == ecic_pkg::ADDR_PEND);
			end
			default: ;
		endcase
		lane_ctrl = accept ? ctrl : '0;
	end

	// One lane per interrupt line; missing lines read as zero.
	for (genvar n = 0; n < ecic_pkg::LINES_MAX; n++) begin : g_lane
		if (n < NUM_LINES) begin : g_on
			ecic_lane #(
				.LINE      (n),
				.NUM_PORTS (NUM_PORTS)
			) u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (lane_ctrl),
				.sel       (port_sel_q[ecic_pkg::SEL_W*n +: ecic_pkg::SEL_W]),
				.pins_low  (pins_low),
				.pins_high (pins_high),
				.rise_en   (rise_en_q[n]),
				.fall_en   (fall_en_q[n]),
				.wr_bit    (write_data[n]),
				.pend_nx   (pend_nx[n]),
				.mask_nx   (mask_nx[n])
			);
		end else begin : g_off
			assign pend_nx[n] = 1'b0;
			assign mask_nx[n] = 1'b0;
		end
	end

	// Merge of the lanes into one result.
	ecic_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ctrl         (ctrl),
		.pend_nx      (pend_nx),
		.mask_nx      (mask_nx),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.irq_requests (irq_requests)
	);

endmodule
